@@ rtl/alc_pkg.sv @@
// Shared constants and types for the array list engine.
package alc_pkg;

    localparam int LIST_DEPTH = 32;
    localparam int IDX_W      = $clog2(LIST_DEPTH);
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int DATA_W     = 32;

    localparam logic [2:0] OP_CLEAR  = 3'd0;
    localparam logic [2:0] OP_INSERT = 3'd1;
    localparam logic [2:0] OP_DELETE = 3'd2;
    localparam logic [2:0] OP_SEARCH = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_POS   = 3'd1;
    localparam logic [2:0] ST_EMPTY     = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    typedef enum logic [1:0] {
        SEL_HOLD,
        SEL_LOWER,
        SEL_UPPER,
        SEL_LOAD
    } cell_sel_t;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

endpackage

@@ rtl/alc_cell.sv @@
// One list entry: holds its value or takes it from a neighbour or the input.
module alc_cell
    import alc_pkg::*;
(
    input  logic              clk,
    input  cell_sel_t         sel,
    input  logic [DATA_W-1:0] lower,
    input  logic [DATA_W-1:0] upper,
    input  logic [DATA_W-1:0] load_value,
    output logic [DATA_W-1:0] value
);

    logic [DATA_W-1:0] value_reg;
    logic [DATA_W-1:0] value_next;

    always_comb
    begin
        unique case (sel)
            SEL_LOWER: value_next = lower;
            SEL_UPPER: value_next = upper;
            SEL_LOAD:  value_next = load_value;
            default:   value_next = value_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

@@ rtl/array_list_engine_top.sv @@
// Top level of the array list engine: command decode, scan sequencer and cell chain.
//
// A transfer happens when start is high and busy is low. Clear, insert, delete,
// unknown operations and reads that fail their checks need no scan: the
// result appears with done the cycle after the transfer and busy stays low, so
// such commands may be issued every cycle. Search and a valid read rotate the
// whole chain of LIST_DEPTH cells once, watching the head cell as it goes; busy
// is high for the whole rotation and the result follows with done in the next
// cycle. done is a single-cycle strobe and cannot be held off: the receiver
// must take status, found_position, read_value and entry_count in that cycle.
module array_list_engine_top
    import alc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [2:0]         op,
    input  logic [5:0]         position,
    input  logic signed [31:0] item_value,
    output logic               busy,
    output logic               done,
    output logic [2:0]         status,
    output logic [4:0]         found_position,
    output logic signed [31:0] read_value,
    output logic [5:0]         entry_count
);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              done_reg, done_next;

    logic [IDX_W-1:0]  step_reg, step_next;
    logic [IDX_W-1:0]  pos_reg, pos_next;
    logic [DATA_W-1:0] key_reg, key_next;
    logic              is_read_reg, is_read_next;
    logic              found_reg, found_next;
    logic [IDX_W-1:0]  found_pos_reg, found_pos_next;
    logic [DATA_W-1:0] rd_reg, rd_next;

    logic [2:0]        status_reg, status_next;
    logic [IDX_W-1:0]  found_position_reg, found_position_next;
    logic [DATA_W-1:0] read_value_reg, read_value_next;
    logic [CNT_W-1:0]  entry_count_reg, entry_count_next;

    cell_sel_t         cell_sel   [LIST_DEPTH];
    logic [DATA_W-1:0] cell_value [LIST_DEPTH];

    logic              accept;
    logic [31:0]       pos_w;
    logic [31:0]       cnt_w;
    logic              list_empty;
    logic              insert_ok;
    logic              delete_ok;
    logic              read_ok;
    logic              last_step;
    logic              hit;
    logic [DATA_W-1:0] head;

    // ---------------------------------------------------------------- decode
    assign accept     = start && (state_reg == S_IDLE);
    assign pos_w      = 32'(position);
    assign cnt_w      = 32'(count_reg);
    assign list_empty = (count_reg == '0);
    assign insert_ok  = (pos_w <= cnt_w) && (cnt_w < 32'(LIST_DEPTH));
    assign delete_ok  = !list_empty && (pos_w < cnt_w);
    assign read_ok    = delete_ok;

    // Entry number step sits in cell 0 during a scan
    assign head      = cell_value[0];
    assign last_step = (step_reg == IDX_W'(LIST_DEPTH - 1));
    assign hit       = (head == key_reg) && (32'(step_reg) < cnt_w) && !found_reg;

    // ------------------------------------------------------------ cell chain
    for (genvar g = 0; g < LIST_DEPTH; g++)
    begin : g_cell
        logic [DATA_W-1:0] lower_value;

        if (g == 0)
        begin : g_head
            assign lower_value = '0;
        end
        else
        begin : g_body
            assign lower_value = cell_value[g-1];
        end

        alc_cell u_cell (
            .clk        (clk),
            .sel        (cell_sel[g]),
            .lower      (lower_value),
            .upper      (cell_value[(g + 1) % LIST_DEPTH]),
            .load_value (item_value),
            .value      (cell_value[g])
        );
    end

    // ------------------------------------------------------------ next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && ((op == OP_SEARCH) || ((op == OP_READ) && read_ok)))
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (last_step)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // --------------------------------------------------------------- outputs
    always_comb
    begin
        busy = (state_reg == S_SCAN);
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            cell_sel[i] = SEL_HOLD;
            if (state_reg == S_SCAN)
            begin
                cell_sel[i] = SEL_UPPER;
            end
            else if (accept && (op == OP_INSERT) && insert_ok)
            begin
                if (32'(i) == pos_w)
                begin
                    cell_sel[i] = SEL_LOAD;
                end
                else if (32'(i) > pos_w)
                begin
                    cell_sel[i] = SEL_LOWER;
                end
            end
            else if (accept && (op == OP_DELETE) && delete_ok)
            begin
                if (32'(i) >= pos_w)
                begin
                    cell_sel[i] = SEL_UPPER;
                end
            end
        end
    end

    // -------------------------------------------------------------- datapath
    always_comb
    begin
        count_next          = count_reg;
        done_next           = 1'b0;
        step_next           = step_reg;
        pos_next            = pos_reg;
        key_next            = key_reg;
        is_read_next        = is_read_reg;
        found_next          = found_reg;
        found_pos_next      = found_pos_reg;
        rd_next             = rd_reg;
        status_next         = status_reg;
        found_position_next = found_position_reg;
        read_value_next     = read_value_reg;
        entry_count_next    = entry_count_reg;

        if (accept)
        begin
            found_position_next = '0;
            read_value_next     = '0;
            status_next         = ST_OK;
            entry_count_next    = count_reg;
            unique case (op)
                OP_CLEAR:
                begin
                    count_next       = '0;
                    entry_count_next = '0;
                    done_next        = 1'b1;
                end
                OP_INSERT:
                begin
                    done_next = 1'b1;
                    if (pos_w > cnt_w)
                    begin
                        status_next = ST_BAD_POS;
                    end
                    else if (!insert_ok)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        count_next       = count_reg + CNT_W'(1);
                        entry_count_next = count_reg + CNT_W'(1);
                    end
                end
                OP_DELETE:
                begin
                    done_next = 1'b1;
                    if (list_empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else if (!delete_ok)
                    begin
                        status_next = ST_BAD_POS;
                    end
                    else
                    begin
                        count_next       = count_reg - CNT_W'(1);
                        entry_count_next = count_reg - CNT_W'(1);
                    end
                end
                OP_SEARCH:
                begin
                    key_next     = item_value;
                    is_read_next = 1'b0;
                    found_next   = 1'b0;
                    step_next    = '0;
                end
                OP_READ:
                begin
                    if (list_empty)
                    begin
                        status_next = ST_EMPTY;
                        done_next   = 1'b1;
                    end
                    else if (!read_ok)
                    begin
                        status_next = ST_BAD_POS;
                        done_next   = 1'b1;
                    end
                    else
                    begin
                        pos_next     = IDX_W'(position);
                        is_read_next = 1'b1;
                        found_next   = 1'b0;
                        step_next    = '0;
                    end
                end
                default:
                begin
                    done_next = 1'b1;
                end
            endcase
        end
        else if (state_reg == S_SCAN)
        begin
            step_next = step_reg + IDX_W'(1);
            if (hit)
            begin
                found_next     = 1'b1;
                found_pos_next = step_reg;
            end
            if (is_read_reg && (step_reg == pos_reg))
            begin
                rd_next = head;
            end
            if (last_step)
            begin
                done_next           = 1'b1;
                entry_count_next    = count_reg;
                found_position_next = '0;
                read_value_next     = '0;
                status_next         = ST_OK;
                if (is_read_reg)
                begin
                    read_value_next = (step_reg == pos_reg) ? head : rd_reg;
                end
                else if (hit)
                begin
                    found_position_next = step_reg;
                end
                else if (found_reg)
                begin
                    found_position_next = found_pos_reg;
                end
                else
                begin
                    status_next = ST_NOT_FOUND;
                end
            end
        end
    end

    // ------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg           <= step_next;
        pos_reg            <= pos_next;
        key_reg            <= key_next;
        is_read_reg        <= is_read_next;
        found_reg          <= found_next;
        found_pos_reg      <= found_pos_next;
        rd_reg             <= rd_next;
        status_reg         <= status_next;
        found_position_reg <= found_position_next;
        read_value_reg     <= read_value_next;
        entry_count_reg    <= entry_count_next;
    end

    assign done           = done_reg;
    assign status         = status_reg;
    assign found_position = 5'(found_position_reg);
    assign read_value     = read_value_reg;
    assign entry_count    = 6'(entry_count_reg);

endmodule
